/* hdl/ccfb_pkg.sv */
// ccfb_pkg: frame constants, byte positions and the per-channel crc table
// for the channel command frame builder; no dependencies
package ccfb_pkg;

    localparam int unsigned FRAME_LEN = 19;
    localparam int unsigned INNER_LEN = 12;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

    typedef logic [IDX_W-1:0] idx_t;

    // frame bytes that never change
    localparam logic [7:0] HDR0      = 8'h57;
    localparam logic [7:0] HDR1      = 8'h59;
    localparam logic [7:0] HDR2      = 8'h02;
    localparam logic [7:0] HDR3      = 8'h00;
    localparam logic [7:0] HDR_LEN   = 8'(INNER_LEN);
    localparam logic [7:0] SYNC0     = 8'hAA;
    localparam logic [7:0] SYNC1     = 8'h55;
    localparam logic [7:0] PAD       = 8'h00;
    localparam logic [7:0] MARK      = 8'hDA;
    localparam logic [7:0] TAIL_BYTE = 8'hAA;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // byte positions within the frame
    localparam idx_t POS_HDR0    = idx_t'(0);
    localparam idx_t POS_HDR1    = idx_t'(1);
    localparam idx_t POS_HDR2    = idx_t'(2);
    localparam idx_t POS_HDR3    = idx_t'(3);
    localparam idx_t POS_LEN     = idx_t'(4);
    localparam idx_t POS_SYNC0   = idx_t'(5);
    localparam idx_t POS_SYNC1   = idx_t'(6);
    localparam idx_t POS_PAD     = idx_t'(7);
    localparam idx_t POS_CHANNEL = idx_t'(8);
    localparam idx_t POS_MARK0   = idx_t'(9);
    localparam idx_t POS_MARK1   = idx_t'(10);
    localparam idx_t POS_CRC_LO  = idx_t'(11);
    localparam idx_t POS_CRC_HI  = idx_t'(12);
    localparam idx_t POS_ZERO0   = idx_t'(13);
    localparam idx_t POS_ZERO3   = idx_t'(16);
    localparam idx_t POS_SUM     = idx_t'(17);
    localparam idx_t POS_TAIL    = idx_t'(18);

    // sum of the constant bytes among the first 17, modulo 256
    localparam logic [7:0] SUM_BASE = 8'(HDR0 + HDR1 + HDR2 + HDR3 + HDR_LEN
                                        + SYNC0 + SYNC1 + PAD + MARK + MARK);

    typedef struct packed {
        logic [7:0]  channel;
        logic [15:0] crc;
        logic [7:0]  sum;
    } calc_t;

    typedef logic [255:0][15:0] crc_table_t;

    // crc-16/ccitt-false over the inner packet, crc slots taken as zero
    function automatic logic [15:0] crc_of_channel(input logic [7:0] ch);
        logic [INNER_LEN-1:0][7:0] inner;
        logic [15:0] crc;
        inner = '0;
        inner[0] = SYNC0;
        inner[1] = SYNC1;
        inner[2] = PAD;
        inner[3] = ch;
        inner[4] = MARK;
        inner[5] = MARK;
        crc = CRC_INIT;
        for (int i = 0; i < INNER_LEN; i++)
        begin
            crc = crc ^ {inner[i], 8'h00};
            for (int b = 0; b < 8; b++)
            begin
                if (crc[15])
                begin
                    crc = {crc[14:0], 1'b0} ^ CRC_POLY;
                end
                else
                begin
                    crc = {crc[14:0], 1'b0};
                end
            end
        end
        return crc;
    endfunction

    function automatic crc_table_t build_crc_table();
        crc_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = crc_of_channel(8'(i));
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage

/* hdl/ccfb_calc.sv */
// ccfb_calc: input register for the channel and crc/checksum lookup
// depends on ccfb_pkg
module ccfb_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          s_tdata,   // [7:0] channel
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                calc_valid,
    input  logic                calc_take,
    output ccfb_pkg::calc_t     calc
);
    import ccfb_pkg::*;

    logic [7:0] ch_reg;
    logic       valid_reg;
    logic       valid_next;
    logic [15:0] crc;

    assign s_tready   = !valid_reg || calc_take;
    assign calc_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (calc_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ch_reg <= s_tdata;
        end
    end

    assign crc = CRC_TABLE[ch_reg];

    always_comb
    begin
        calc.channel = ch_reg;
        calc.crc     = crc;
        calc.sum     = SUM_BASE + ch_reg + crc[7:0] + crc[15:8];
    end

endmodule

/* hdl/ccfb_ser.sv */
// ccfb_ser: frame holding register, byte index and output register
// depends on ccfb_pkg
module ccfb_ser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                calc_valid,
    output logic                calc_take,
    input  ccfb_pkg::calc_t     calc,
    output logic [7:0]          m_tdata,   // [7:0] frame_byte
    output logic                m_tlast,
    output logic                m_tvalid,
    input  logic                m_tready
);
    import ccfb_pkg::*;

    calc_t      frame_reg;
    logic       busy_reg;
    logic       busy_next;
    idx_t       idx_reg;
    idx_t       idx_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       tvalid_reg;
    logic       tvalid_next;
    logic       out_free;
    logic       emit;
    logic       idx_last;
    logic [7:0] byte_sel;

    assign out_free  = !tvalid_reg || m_tready;
    assign emit      = busy_reg && out_free;
    assign idx_last  = (idx_reg == POS_TAIL);
    // next frame loads as the current tail byte leaves for the output register
    assign calc_take = calc_valid && (!busy_reg || (emit && idx_last));

    always_comb
    begin
        case (idx_reg) inside
            POS_HDR0:              byte_sel = HDR0;
            POS_HDR1:              byte_sel = HDR1;
            POS_HDR2:              byte_sel = HDR2;
            POS_HDR3:              byte_sel = HDR3;
            POS_LEN:               byte_sel = HDR_LEN;
            POS_SYNC0:             byte_sel = SYNC0;
            POS_SYNC1:             byte_sel = SYNC1;
            POS_PAD:               byte_sel = PAD;
            POS_CHANNEL:           byte_sel = frame_reg.channel;
            POS_MARK0, POS_MARK1:  byte_sel = MARK;
            POS_CRC_LO:            byte_sel = frame_reg.crc[7:0];
            POS_CRC_HI:            byte_sel = frame_reg.crc[15:8];
            [POS_ZERO0:POS_ZERO3]: byte_sel = PAD;
            POS_SUM:               byte_sel = frame_reg.sum;
            POS_TAIL:              byte_sel = TAIL_BYTE;
            default:               byte_sel = PAD;
        endcase
    end

    always_comb
    begin
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        tvalid_next = tvalid_reg;
        if (emit)
        begin
            tvalid_next = 1'b1;
            if (idx_last)
            begin
                idx_next  = '0;
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + idx_t'(1);
            end
        end
        else if (out_free)
        begin
            tvalid_next = 1'b0;
        end
        if (calc_take)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_take)
        begin
            frame_reg <= calc;
        end
        if (emit)
        begin
            data_reg <= byte_sel;
            last_reg <= idx_last;
        end
    end

    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tvalid = tvalid_reg;

endmodule

/* hdl/channel_command_frame_builder_top.sv */
// channel_command_frame_builder_top: top level of the command frame builder
// depends on ccfb_pkg, ccfb_calc and ccfb_ser
//
// usage
//   slave channel (s_*): one beat carries a channel number in s_tdata[7:0]
//   master channel (m_*): 19 beats per channel, one frame byte each, m_tlast
//   high on the closing tail byte; frame is 57 59 02 00 0C, inner packet
//   AA 55 00 ch DA DA crc_lo crc_hi 00 00 00 00, 8-bit sum, AA
//   the crc and checksum come from a constant per-channel table plus one
//   byte adder, registered with the frame before it is sent out
// path: a channel passes the input register, the frame holding register and
//   the output register; the channel rate is set by the byte-wide output port;
//   the next channel is taken into the input register while a frame is still
//   going out and its frame follows the previous tail byte with no gap
// reset: clears all valid flags and the byte index; no frame is in flight
// stall: when m_tready is low the current byte holds; once the input
//   register is full, s_tready drops until the running frame ends
module channel_command_frame_builder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] s_tdata,   // [7:0] channel
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic [7:0] m_tdata,   // [7:0] frame_byte
    output logic       m_tlast,
    output logic       m_tvalid,
    input  logic       m_tready
);
    import ccfb_pkg::*;

    logic  calc_valid;
    logic  calc_take;
    calc_t calc;

    ccfb_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .calc_valid (calc_valid),
        .calc_take  (calc_take),
        .calc       (calc)
    );

    ccfb_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .calc_valid (calc_valid),
        .calc_take  (calc_take),
        .calc       (calc),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready)
    );

`ifndef NO_ASSERTIONS
    // the closing beat is always the tail byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == TAIL_BYTE)
        else $error("last beat is not the tail byte");

    // within a frame the bytes run without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a frame");

    // a new frame opens with the first header byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata == HDR0)
        else $error("frame does not start with header");
`endif

endmodule

/* sim/channel_command_frame_builder_top_tb.sv */
// channel_command_frame_builder_top_tb: self-checking bench for the frame builder
// predicts every 19-byte frame, crc and checksum included, from the channel number
// depends on channel_command_frame_builder_top and the rtl it pulls in
module channel_command_frame_builder_top_tb;

    localparam int unsigned FRAME_BYTES = 19;
    localparam int unsigned INNER_OFS   = 5;
    localparam int unsigned INNER_BYTES = 12;
    localparam int unsigned POS_CHAN    = 8;
    localparam int unsigned POS_CRC_LO  = 11;
    localparam int unsigned POS_CRC_HI  = 12;
    localparam int unsigned POS_SUM     = 17;
    localparam int unsigned POS_TAIL    = 18;

    localparam logic [7:0]  HDR_A      = 8'h57;
    localparam logic [7:0]  HDR_B      = 8'h59;
    localparam logic [7:0]  HDR_C      = 8'h02;
    localparam logic [7:0]  HDR_D      = 8'h00;
    localparam logic [7:0]  HDR_LENGTH = 8'h0C;
    localparam logic [7:0]  SYNC_A     = 8'hAA;
    localparam logic [7:0]  SYNC_B     = 8'h55;
    localparam logic [7:0]  MARKER     = 8'hDA;
    localparam logic [7:0]  TAIL       = 8'hAA;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CRC_GEN    = 16'h1021;

    localparam int unsigned RANDOM_CHANNELS = 70;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned SETTLE_CYCLES   = 20;
    localparam int unsigned MAX_PRINTED     = 100;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;

    frame_beat_t expected_beats[$];

    int unsigned error_count     = 0;
    int unsigned beats_checked   = 0;
    int unsigned channels_sent   = 0;
    int unsigned idle_cycles     = 0;
    int unsigned hold_left       = 0;
    int unsigned hold_cycles_run = 0;
    int unsigned burst_left      = 0;
    bit          hold_req        = 1'b0;
    bit          no_gaps         = 1'b0;

    channel_command_frame_builder_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // crc-16/ccitt-false, one byte msb first
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_GEN;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // queue up the whole frame that one channel number should produce
    function automatic void predict_frame(input logic [7:0] ch);
        logic [7:0]  frame [FRAME_BYTES];
        logic [15:0] crc;
        logic [7:0]  sum;
        frame_beat_t beat;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame[i] = 8'h00;
        end
        frame[0] = HDR_A;
        frame[1] = HDR_B;
        frame[2] = HDR_C;
        frame[3] = HDR_D;
        frame[4] = HDR_LENGTH;
        frame[INNER_OFS]     = SYNC_A;
        frame[INNER_OFS + 1] = SYNC_B;
        frame[POS_CHAN]      = ch;
        frame[POS_CHAN + 1]  = MARKER;
        frame[POS_CHAN + 2]  = MARKER;
        // crc slots are still zero here
        crc = CRC_SEED;
        for (int i = INNER_OFS; i < INNER_OFS + INNER_BYTES; i++)
        begin
            crc = crc_ccitt_step(crc, frame[i]);
        end
        frame[POS_CRC_LO] = crc[7:0];
        frame[POS_CRC_HI] = crc[15:8];
        sum = 8'h00;
        for (int i = 0; i < POS_SUM; i++)
        begin
            sum = sum + frame[i];
        end
        frame[POS_SUM]  = sum;
        frame[POS_TAIL] = TAIL;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            beat.data = frame[i];
            beat.last = (i == POS_TAIL);
            expected_beats.push_back(beat);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        if (error_count < MAX_PRINTED)
        begin
            $display("mismatch at beat %0d: %s expected %h got %h",
                     beats_checked, what, want, got);
        end
        error_count++;
    endtask

    // offer one channel and hold it until taken; bursts with random gaps between them
    task automatic send_channel(input logic [7:0] ch);
        s_tdata  <= ch;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_frame(ch);
        channels_sent++;
        if (!no_gaps)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(0, 6);
            end
        end
    endtask

    task automatic wait_for_frames();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // all zeros, all ones, walking ones and zeros, alternating patterns
    task automatic test_directed_channels();
        send_channel(8'h00);
        send_channel(8'hFF);
        send_channel(8'h55);
        send_channel(8'hAA);
        for (int i = 0; i < 8; i++)
        begin
            send_channel(8'h01 << i);
        end
        for (int i = 0; i < 8; i++)
        begin
            send_channel(~(8'h01 << i));
        end
        wait_for_frames();
    endtask

    task automatic test_random_channels();
        for (int i = 0; i < RANDOM_CHANNELS; i++)
        begin
            send_channel(8'($urandom_range(0, 255)));
        end
        wait_for_frames();
    endtask

    // receiver holds off for a long stretch while channels keep coming
    task automatic test_output_hold_off();
        no_gaps = 1'b1;
        send_channel(8'($urandom_range(0, 255)));
        hold_req = 1'b1;
        for (int i = 0; i < 11; i++)
        begin
            send_channel(8'($urandom_range(0, 255)));
        end
        no_gaps = 1'b0;
        wait_for_frames();
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned phase;
        mode      = RX_STEADY;
        mode_left = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
                hold_cycles_run++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_STEADY: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= (phase % 4 == 0);
                endcase
            end
        end
    end

    // compare each output beat with the oldest predicted one
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat, data", 8'h00, m_tdata);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.data)
                begin
                    report_mismatch("frame_byte", want.data, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch("frame_last", {7'b0, want.last}, {7'b0, m_tlast});
                end
            end
            beats_checked++;
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d beats outstanding",
                         IDLE_LIMIT, expected_beats.size());
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_channels();
        test_random_channels();
        test_output_hold_off();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d channels framed, %0d frame bytes checked against predicted crc and sum",
                 channels_sent, beats_checked);
        $display("receiver stalls included a %0d-cycle hold-off with the input kept busy",
                 hold_cycles_run);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/ccfb_pkg.sv
hdl/ccfb_calc.sv
hdl/ccfb_ser.sv
hdl/channel_command_frame_builder_top.sv
sim/channel_command_frame_builder_top_tb.sv
